// ===== rtl/nnpo_pkg.sv =====
package nnpo_pkg;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 33;
  localparam logic [15:0] CUT_MIN = 16'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      out_last;
    logic                      overflowed;
  } out_beat_t;
endpackage

// ===== rtl/nnpo_if.sv =====
interface nnpo_in_if;
  import nnpo_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nnpo_out_if;
  import nnpo_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nnpo_dist.sv =====
module nnpo_dist (
  input  logic                            clk,
  input  logic signed [nnpo_pkg::COORD_W-1:0] ax,
  input  logic signed [nnpo_pkg::COORD_W-1:0] ay,
  input  logic signed [nnpo_pkg::COORD_W-1:0] bx,
  input  logic signed [nnpo_pkg::COORD_W-1:0] by,
  output logic [nnpo_pkg::DIST_W-1:0]         sq_d
);
  import nnpo_pkg::*;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0] adx, ady;
  logic [2*COORD_W+1:0] sx_r, sy_r;

  always_comb begin
    dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    adx = dx[COORD_W] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[COORD_W] ? $unsigned(-dy) : $unsigned(dy);
  end

  // one square per operand, registered before the add
  always_ff @(posedge clk) begin
    sx_r <= adx * adx;
    sy_r <= ady * ady;
  end

  assign sq_d = DIST_W'(sx_r[2*COORD_W-1:0]) + DIST_W'(sy_r[2*COORD_W-1:0]);
endmodule

// ===== rtl/nearest_neighbor_point_orderer_unit.sv =====
// channel | dir | payload                               | handshake
// in_     | in  | point_x, point_y, last_point          | valid/ready
// out_    | out | out_x, out_y, out_last, overflowed    | valid/ready
// cfg_    | in  | jump limit                            | write enable
// loading takes one cycle a point; the set closes on last_point and input ready drops.
// ordering, per step i: setup, a scan of points i+1..n-1 (one read and compare a cycle),
// a drain of the compare pipeline, then the jump-limit cutoff or a swap in S_SW0..S_SW2.
// emission goes through S_EMIT, S_EMIT_W and S_OUT a beat; a held-off beat stalls in place.
// reset clears the point counter, overflow flag and jump limit, not the point memory.
module nearest_neighbor_point_orderer_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  nnpo_in_if.sink    in_ch,
  nnpo_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import nnpo_pkg::*;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_CUR, S_CUR_W, S_SCAN, S_DRAIN, S_SW0, S_SW1, S_SW2, S_EMIT, S_EMIT_W, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r, n_r;
  logic ovf_r;
  logic [15:0] jump_lim_r;
  logic [AW-1:0] i_r, k_r, best_r, rd_addr;
  logic [CW-1:0] kk_r;
  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_W-1:0] rx_r, ry_r, cx_r, cy_r;
  logic [DIST_W-1:0] sq_d, dmin_r;
  logic first_r;
  logic [2:0] vpipe_r;
  logic [AW-1:0] kp1_r, kp2_r;
  logic we;
  logic [AW-1:0] wa;
  logic signed [COORD_W-1:0] wx, wy;
  out_beat_t obuf_r;
  logic oval_r;
  logic [31:0] limit;

  assign limit = jump_lim_r * jump_lim_r;
  nnpo_dist u_dist (.clk(clk), .ax(cx_r), .ay(cy_r), .bx(rx_r), .by(ry_r), .sq_d(sq_d));

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[wa] <= wx;
      mem_y[wa] <= wy;
    end
    rx_r <= mem_x[rd_addr];
    ry_r <= mem_y[rd_addr];
  end

  assign in_ch.ready = (state_r == S_LOAD);
  assign out_ch.valid = oval_r;
  assign out_ch.data = obuf_r;

  always_comb begin
    we = 1'b0; wa = cnt_r[AW-1:0]; wx = in_ch.data.point_x; wy = in_ch.data.point_y;
    rd_addr = k_r;
    case (state_r)
      S_LOAD: we = in_ch.valid && (cnt_r < CW'(MAX_POINTS));
      S_CUR:  rd_addr = i_r;
      // read best while its slot takes the old point i+1
      S_SW1:  begin rd_addr = best_r; we = 1'b1; wa = best_r; wx = rx_r; wy = ry_r; end
      S_SW2:  begin we = 1'b1; wa = AW'(i_r + 1'b1); wx = rx_r; wy = ry_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; jump_lim_r <= '0;
      oval_r <= 1'b0; vpipe_r <= '0;
    end else begin
      if (cfg_we) jump_lim_r <= cfg_wdata;
      vpipe_r <= {vpipe_r[1:0], state_r == S_SCAN};
      kp1_r <= k_r; kp2_r <= kp1_r;
      case (state_r)
        S_LOAD: if (in_ch.valid) begin
          if (cnt_r < CW'(MAX_POINTS)) cnt_r <= cnt_r + 1'b1;
          else ovf_r <= 1'b1;
          if (in_ch.data.last_point) begin
            n_r <= (cnt_r < CW'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
            i_r <= '0;
            state_r <= S_CUR;
          end
        end
        S_CUR: begin
          if (CW'(i_r) + 1'b1 >= n_r) begin
            k_r <= '0; state_r <= S_EMIT;
          end else begin
            state_r <= S_CUR_W;
          end
        end
        S_CUR_W: begin
          cx_r <= rx_r; cy_r <= ry_r;
          k_r <= AW'(i_r + 1'b1); kk_r <= CW'(i_r) + 1'b1;
          first_r <= 1'b1; state_r <= S_SCAN;
        end
        S_SCAN: begin
          k_r <= k_r + 1'b1; kk_r <= kk_r + 1'b1;
          if (kk_r + 1'b1 >= n_r) state_r <= S_DRAIN;
        end
        S_DRAIN: if (vpipe_r[2:1] == 2'b00 && !vpipe_r[0]) begin
          if (jump_lim_r >= CUT_MIN && dmin_r > DIST_W'(limit)) begin
            n_r <= CW'(i_r) + 1'b1; k_r <= '0; state_r <= S_EMIT;
          end else begin
            k_r <= AW'(i_r + 1'b1); state_r <= S_SW0;
          end
        end
        S_SW0: state_r <= S_SW1;  // rd i+1 (k_r) now, best next
        S_SW1: state_r <= S_SW2;
        S_SW2: begin i_r <= i_r + 1'b1; state_r <= S_CUR; end
        S_EMIT: state_r <= S_EMIT_W;
        S_EMIT_W: begin
          obuf_r.out_x <= rx_r; obuf_r.out_y <= ry_r;
          obuf_r.out_last <= (CW'(k_r) + 1'b1 == n_r);
          obuf_r.overflowed <= ovf_r;
          oval_r <= 1'b1; state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          oval_r <= 1'b0;
          if (obuf_r.out_last) begin
            cnt_r <= '0; ovf_r <= 1'b0; state_r <= S_LOAD;
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_EMIT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      // distance for index kp2 is valid when vpipe[1] set (read + square stage)
      if (vpipe_r[1]) begin
        if (first_r || sq_d < dmin_r) begin
          dmin_r <= sq_d; best_r <= kp2_r;
        end
        first_r <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/nnpo_checker.sv =====
module nnpo_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("load during emit");
  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("beat after last");
  a_in_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("beat right after load");
endmodule

bind nearest_neighbor_point_orderer_unit nnpo_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.data.out_last));

// ===== dv/tb_nearest_neighbor_point_orderer_unit.sv =====
`timescale 1ns / 1ps

module tb_nearest_neighbor_point_orderer_unit;
  import nnpo_pkg::*;

  localparam int CAP = 64;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  nnpo_in_if in_ch ();
  nnpo_out_if out_ch ();

  nearest_neighbor_point_orderer_unit #(.MAX_POINTS(CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [15:0] set_x [CAP];
  logic signed [15:0] set_y [CAP];
  int unsigned set_cnt;
  bit set_dropped;
  logic [15:0] jump_limit;

  out_beat_t ordered_q[$];
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic longint sq_gap(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                    input logic signed [15:0] bx, input logic signed [15:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  // greedy walk over the closed set, queueing the emitted points
  function automatic void order_set();
    int unsigned n;
    int unsigned best;
    longint dmin;
    longint d;
    longint lim;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    out_beat_t b;
    n = set_cnt;
    lim = longint'(jump_limit) * longint'(jump_limit);
    for (int unsigned i = 0; i + 1 < set_cnt; i++) begin
      best = i + 1;
      dmin = sq_gap(set_x[i], set_y[i], set_x[best], set_y[best]);
      for (int unsigned k = i + 2; k < set_cnt; k++) begin
        d = sq_gap(set_x[i], set_y[i], set_x[k], set_y[k]);
        if (d < dmin) begin
          dmin = d;
          best = k;
        end
      end
      if (jump_limit >= CUT_MIN && dmin > lim) begin
        n = i + 1;
        break;
      end
      tx = set_x[i+1];
      ty = set_y[i+1];
      set_x[i+1] = set_x[best];
      set_y[i+1] = set_y[best];
      set_x[best] = tx;
      set_y[best] = ty;
    end
    for (int unsigned k = 0; k < n; k++) begin
      b.out_x = set_x[k];
      b.out_y = set_y[k];
      b.out_last = (k + 1 == n);
      b.overflowed = set_dropped;
      ordered_q = {ordered_q, b};
    end
    set_cnt = 0;
    set_dropped = 0;
  endfunction

  function automatic void absorb_point(input in_beat_t p);
    if (set_cnt < CAP) begin
      set_x[set_cnt] = p.point_x;
      set_y[set_cnt] = p.point_y;
      set_cnt++;
    end else begin
      set_dropped = 1;
    end
    if (p.last_point) order_set();
  endfunction

  // leaves valid high on return; park_input, or an idle gap in the next call, takes it down
  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last);
    in_beat_t p;
    p.point_x = x;
    p.point_y = y;
    p.last_point = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(posedge clk); while (!in_ch.ready);
    absorb_point(p);
  endtask

  task automatic park_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    park_input();
    while (ordered_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_jump(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    jump_limit = v;
  endtask

  task automatic send_random_set(input int unsigned n, input bit wide);
    logic [15:0] bx;
    logic [15:0] by;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int unsigned k = 0; k < n; k++) begin
      if (wide) send_point(16'($urandom), 16'($urandom), k + 1 == n);
      else send_point(16'(bx + $urandom_range(255)), 16'(by + $urandom_range(255)), k + 1 == n);
    end
  endtask

  // results: one checker for every beat
  always @(posedge clk) begin
    out_beat_t e;
    out_beat_t g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (ordered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d", g.out_x, g.out_y));
      end else begin
        e = ordered_q.pop_front();
        if (g.out_x !== e.out_x) report_mismatch($sformatf("out_x %0d want %0d", g.out_x, e.out_x));
        if (g.out_y !== e.out_y) report_mismatch($sformatf("out_y %0d want %0d", g.out_y, e.out_y));
        if (g.out_last !== e.out_last)
          report_mismatch($sformatf("out_last %0b want %0b", g.out_last, e.out_last));
        if (g.overflowed !== e.overflowed)
          report_mismatch($sformatf("overflowed %0b want %0b", g.overflowed, e.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    write_jump(16'd0);
    send_point(16'sh7fff, 16'sh8000, 1);
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh7fff, 1);
    // equal distances: lowest index wins
    send_point(0, 0, 0);
    send_point(16, 0, 0);
    send_point(0, 16, 0);
    send_point(16'shfff0, 0, 0);
    send_point(0, 16'shfff0, 1);
    send_point(0, 0, 0);
    send_point(100, 0, 0);
    send_point(10, 0, 0);
    send_point(50, 0, 1);
    wait_drained();
    // cutoff disabled at one
    write_jump(16'd1);
    send_point(0, 0, 0);
    send_point(5, 0, 0);
    send_point(2, 0, 1);
    wait_drained();
    // smallest enabled cutoff
    write_jump(16'd2);
    send_point(0, 0, 0);
    send_point(2, 0, 0);
    send_point(3, 1, 0);
    send_point(4, 2, 1);
    wait_drained();
    write_jump(16'hffff);
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh7fff, 0);
    send_point(0, 0, 1);
    wait_drained();
  endtask

  task automatic test_overflow();
    write_jump(16'd0);
    send_random_set(66, 0);
    // exactly full, no drop
    send_random_set(64, 1);
    wait_drained();
  endtask

  task automatic test_pressure();
    recv_hold = 3000;
    send_random_set(24, 0);
    send_random_set(16, 0);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned items);
    int unsigned sent;
    int unsigned n;
    logic [15:0] cfg_vals [5] = '{16'd0, 16'd2, 16'd100, 16'd3000, 16'hffff};
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(5) == 0) begin
        wait_drained();
        write_jump($urandom_range(3) == 0 ? 16'($urandom) : cfg_vals[$urandom_range(4)]);
      end
      n = ($urandom_range(15) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
      send_random_set(n, $urandom_range(2) == 0);
      sent += n;
    end
    wait_drained();
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    recv_hold = 0;
    err_cnt = 0;
    set_cnt = 0;
    set_dropped = 0;
    jump_limit = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 69;
    test_directed();
    test_overflow();
    test_random(10);
    send_idle_pct = 69;
    recv_idle_pct = 19;
    test_random(10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_pressure();
    test_random(10);

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && ordered_q.size() == 0) begin
      $display("tb_nearest_neighbor_point_orderer_unit: clean");
    end else begin
      $display("tb_nearest_neighbor_point_orderer_unit: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_nearest_neighbor_point_orderer_unit: errors");
    $finish;
  end
endmodule
